// ----- sv/rpcf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rpcf_pkg;

   // Filter mode codes held in the mode register
   typedef enum logic [2:0] {
      MODE_PASS     = 3'd0,
      MODE_GRAY     = 3'd1,
      MODE_CLR_RED  = 3'd2,
      MODE_CLR_GRN  = 3'd3,
      MODE_CLR_BLU  = 3'd4,
      MODE_INVERT   = 3'd5,
      MODE_BRIGHTEN = 3'd6,
      MODE_SEPIA    = 3'd7
   } mode_type;

   localparam int CHAN_W   = 8;
   localparam int COEF_W   = 16;
   localparam int PROD_W   = CHAN_W + COEF_W;
   localparam int ACC_W    = PROD_W + 1;
   localparam int GSUM_W   = CHAN_W + 2;
   localparam int GPROD_W  = 2 * GSUM_W;

   localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;
   localparam logic [CHAN_W:0]   BRIGHT_ADD = 9'd38;

   // Divide by three as multiply by 683 then shift right by 11 (exact up to 765)
   localparam logic [GSUM_W-1:0] DIV3_MUL   = 10'd683;
   localparam int                DIV3_SHIFT = 11;

   // Sepia weights, unsigned Q0.16; row is the output channel, column the input
   localparam logic [COEF_W-1:0] SEPIA_COEF [3][3] = '{
      '{16'd23514, 16'd46164, 16'd8965},
      '{16'd19595, 16'd38470, 16'd7471},
      '{16'd15676, 16'd30776, 16'd5977}
   };

   typedef struct packed {
      logic [CHAN_W-1:0] in_red;
      logic [CHAN_W-1:0] in_green;
      logic [CHAN_W-1:0] in_blue;
   } req_pixel_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
   } rsp_pixel_type;

endpackage

`default_nettype wire

// ----- sv/rgb_pixel_color_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Per-pixel RGB color filter.
// Request channel (req_valid, req_stall, req_data) carries one RGB pixel of
// 8-bit channels; the response channel (rsp_valid, rsp_stall, rsp_data)
// returns the filtered pixel. A transfer happens on a clock edge with valid
// high and stall low. csr_write/csr_data load the 3-bit filter mode: pass,
// gray, clear red, clear green, clear blue, invert, brighten or sepia. Change
// it only while no request is in flight.
// Stage one forms the nine sepia products and the gray sum, stage two adds
// the sepia products and scales the gray sum by one third, and stage three
// saturates and selects by mode. Throughput is one pixel per cycle while
// rsp_stall stays low. Each stage holds while the stage after it is full and
// stalled, so a response stall backs up the pipeline one stage at a time and
// req_stall rises only once all three stages are full.
// Synchronous reset empties the pipeline and sets the mode to pass-through.
module rgb_pixel_color_filter (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire rpcf_pkg::req_pixel_type req_data,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      rpcf_pkg::rsp_pixel_type rsp_data,
   input  wire logic                    csr_write,
   input  wire logic [2:0]              csr_data
);
   import rpcf_pkg::*;

   mode_type mode_ff;

   logic                 v1_ff, v2_ff, v3_ff;
   logic                 en1, en2, en3;
   mode_type             mode1_ff, mode2_ff;
   req_pixel_type        pix1_ff, pix2_ff;
   logic [PROD_W-1:0]    prod1_in [3][3];
   logic [PROD_W-1:0]    prod1_ff [3][3];
   logic [GSUM_W-1:0]    gsum1_in, gsum1_ff;
   logic [ACC_W-1:0]     acc2_in [3];
   logic [ACC_W-1:0]     acc2_ff [3];
   logic [GPROD_W-1:0]   gprod;
   logic [CHAN_W-1:0]    gray2_in, gray2_ff;
   logic [CHAN_W-1:0]    chan2 [3];
   logic [CHAN_W-1:0]    sepia [3];
   logic [CHAN_W-1:0]    bright [3];
   logic [CHAN_W:0]      bsum [3];
   logic [CHAN_W-1:0]    res [3];
   rsp_pixel_type        rsp_in, rsp_ff;
   logic [CHAN_W-1:0]    chan_in [3];

   // Hold the mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PASS;
      end else if (csr_write) begin
         mode_ff <= mode_type'(csr_data);
      end
   end

   // Advance a stage when it is empty or its successor takes its content
   assign en3       = !v3_ff || !rsp_stall;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // Stage one: sepia products and gray sum
   assign chan_in[0] = req_data.in_red;
   assign chan_in[1] = req_data.in_green;
   assign chan_in[2] = req_data.in_blue;

   always_comb begin
      for (int o = 0; o < 3; o++) begin
         for (int i = 0; i < 3; i++) begin
            prod1_in[o][i] = PROD_W'(chan_in[i]) * PROD_W'(SEPIA_COEF[o][i]);
         end
      end
      gsum1_in = GSUM_W'(chan_in[0]) + GSUM_W'(chan_in[1]) + GSUM_W'(chan_in[2]);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         mode1_ff <= mode_ff;
         pix1_ff  <= req_data;
         prod1_ff <= prod1_in;
         gsum1_ff <= gsum1_in;
      end
   end

   // Stage two: sepia sums and gray sum divided by three
   always_comb begin
      for (int o = 0; o < 3; o++) begin
         acc2_in[o] = ACC_W'(prod1_ff[o][0]) + ACC_W'(prod1_ff[o][1])
                    + ACC_W'(prod1_ff[o][2]);
      end
      gprod    = GPROD_W'(gsum1_ff) * GPROD_W'(DIV3_MUL);
      gray2_in = gprod[DIV3_SHIFT +: CHAN_W];
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         mode2_ff <= mode1_ff;
         pix2_ff  <= pix1_ff;
         acc2_ff  <= acc2_in;
         gray2_ff <= gray2_in;
      end
   end

   // Stage three: saturate, brighten, invert and select by mode
   assign chan2[0] = pix2_ff.in_red;
   assign chan2[1] = pix2_ff.in_green;
   assign chan2[2] = pix2_ff.in_blue;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sepia[c]  = (acc2_ff[c][ACC_W-1:COEF_W] > (ACC_W-COEF_W)'(CHAN_MAX))
                   ? CHAN_MAX : acc2_ff[c][COEF_W +: CHAN_W];
         bsum[c]   = {1'b0, chan2[c]} + BRIGHT_ADD;
         bright[c] = bsum[c][CHAN_W] ? CHAN_MAX : bsum[c][CHAN_W-1:0];
         res[c]    = chan2[c];
         unique case (mode2_ff)
            MODE_PASS:     res[c] = chan2[c];
            MODE_GRAY:     res[c] = gray2_ff;
            MODE_CLR_RED:  res[c] = (c == 0) ? '0 : chan2[c];
            MODE_CLR_GRN:  res[c] = (c == 1) ? '0 : chan2[c];
            MODE_CLR_BLU:  res[c] = (c == 2) ? '0 : chan2[c];
            MODE_INVERT:   res[c] = CHAN_MAX - chan2[c];
            MODE_BRIGHTEN: res[c] = bright[c];
            MODE_SEPIA:    res[c] = sepia[c];
            default:       res[c] = chan2[c];
         endcase
      end
      rsp_in.out_red   = res[0];
      rsp_in.out_green = res[1];
      rsp_in.out_blue  = res[2];
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
